[rtl/ets_pkg.sv]
`default_nettype none

package ets_pkg;

    localparam int NUM_PORTS_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int INIT_TOKENS_DEF = 100;

    localparam int NUM_RATES  = 4;
    localparam int RATE_W     = 16;
    localparam int TOK_W      = 20;
    localparam int PERIOD_W   = 16;
    localparam int THR_W      = 7;
    localparam int LEN_W      = 16;
    localparam int TAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int MAX_SENDS  = 4;
    localparam int SEND_CNT_W = 3;

    localparam logic [TOK_W-1:0]    CAP_RST    = 20'd65535;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [THR_W-1:0]    THR_RST    = 7'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd6;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        dest_port;
        logic [LEN_W-1:0]  pkt_len;
        logic [TAG_W-1:0]  pkt_tag;
    } in_item_t;

    typedef struct packed {
        logic              sent_valid;
        logic [1:0]        sent_port;
        logic [LEN_W-1:0]  sent_len;
        logic [TAG_W-1:0]  sent_tag;
        logic              dropped;
        logic              busy_res;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [NUM_RATES-1:0][RATE_W-1:0] rate;
        logic [TOK_W-1:0]                 cap;
        logic [PERIOD_W-1:0]              period;
        logic [THR_W-1:0]                 thr;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/ets_ram.sv]
`default_nettype none

module ets_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ets_cfg.sv]
`default_nettype none

module ets_cfg (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire [ets_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire [ets_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output ets_pkg::cfg_t                    cfg
);
    import ets_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate   <= '0;
            cfg_reg.cap    <= CAP_RST;
            cfg_reg.period <= PERIOD_RST;
            cfg_reg.thr    <= THR_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_RATE0:  cfg_reg.rate[0] <= cfg_wdata[RATE_W-1:0];
                CFG_RATE1:  cfg_reg.rate[1] <= cfg_wdata[RATE_W-1:0];
                CFG_RATE2:  cfg_reg.rate[2] <= cfg_wdata[RATE_W-1:0];
                CFG_RATE3:  cfg_reg.rate[3] <= cfg_wdata[RATE_W-1:0];
                CFG_CAP:    cfg_reg.cap     <= cfg_wdata[TOK_W-1:0];
                CFG_PERIOD: cfg_reg.period  <= cfg_wdata[PERIOD_W-1:0];
                CFG_THR:    cfg_reg.thr     <= cfg_wdata[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/egress_token_bucket_shaper.sv]
`default_nettype none

// Per-port egress token-bucket shaper. An arrival item appends (tag, length) to its
// port's FIFO, held in one shared packet RAM. Its one result is registered from the
// S_ARR state, which waits out any output stall, with dropped set when the port is
// out of range or its FIFO is full. A tick item refills the buckets once per refill
// period and updates busy. It then visits the ports in order with one RAM read and
// one check per port, and sends at most four head packets. Each sent packet is one
// result and the final one has last set; a tick with no send gives one empty result.
// Items are taken one at a time.
module egress_token_bucket_shaper #(
    parameter int NUM_PORTS   = ets_pkg::NUM_PORTS_DEF,
    parameter int QUEUE_DEPTH = ets_pkg::QUEUE_DEPTH_DEF,
    parameter int INIT_TOKENS = ets_pkg::INIT_TOKENS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  ets_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output ets_pkg::out_item_t              m_data,
    input  wire                             cfg_we,
    input  wire [ets_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire [ets_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ets_pkg::*;

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int VIS_W  = $clog2(NUM_PORTS + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int ADDR_W = PORT_W + PTR_W;
    localparam int ENT_W  = TAG_W + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ARR, S_REFILL, S_BUSY, S_READ, S_CHECK, S_FLUSH
    } state_t;

    cfg_t cfg;

    ets_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;

    ets_ram #(.WIDTH(ENT_W), .DEPTH(2 ** ADDR_W)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    state_t                state_reg, state_next;
    logic                  drop_reg, drop_next;
    logic [VIS_W-1:0]      p_reg, p_next;
    logic [SEND_CNT_W-1:0] nsent_reg, nsent_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_item_t             pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;
    logic [TOK_W-1:0]      tok_reg [NUM_PORTS];
    logic [TOK_W-1:0]      tok_next [NUM_PORTS];
    logic [PTR_W-1:0]      head_reg [NUM_PORTS];
    logic [PTR_W-1:0]      head_next [NUM_PORTS];
    logic [PTR_W-1:0]      tail_reg [NUM_PORTS];
    logic [PTR_W-1:0]      tail_next [NUM_PORTS];
    logic [CNT_W-1:0]      cnt_reg [NUM_PORTS];
    logic [CNT_W-1:0]      cnt_next [NUM_PORTS];
    logic [PERIOD_W-1:0]   tick_reg, tick_next;
    logic                  busy_reg, busy_next;

    logic                  out_free;
    logic [PORT_W-1:0]     p_idx, a_idx;
    logic [PERIOD_W-1:0]   period, tc0;
    logic [PERIOD_W:0]     tc1;
    logic [LEN_W-1:0]      h_len;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  busy_after;
    logic [TOK_W:0]        sum [NUM_PORTS];

    assign out_free  = !m_valid_reg || m_ready;
    assign p_idx     = p_reg[PORT_W-1:0];
    assign a_idx     = PORT_W'(s_data.dest_port);
    assign ram_raddr = {p_idx, head_reg[p_idx]};
    assign h_len     = ram_rdata[LEN_W-1:0];
    assign cnt_dec   = cnt_reg[p_idx] - CNT_W'(1);
    assign busy_after = (CMP_W'(cnt_dec) < CMP_W'(cfg.thr)) ? 1'b0 : busy_reg;
    assign period    = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
    assign tc0       = (tick_reg >= period) ? '0 : tick_reg;
    assign tc1       = {1'b0, tc0} + (PERIOD_W+1)'(1);

    always_comb begin
        for (int i = 0; i < NUM_PORTS; i++) begin
            sum[i] = {1'b0, tok_reg[i]}
                + ((i < NUM_RATES) ? (TOK_W+1)'(cfg.rate[i % NUM_RATES]) : '0);
        end
    end

    always_comb begin
        state_next      = state_reg;
        drop_next       = drop_reg;
        p_next          = p_reg;
        nsent_next      = nsent_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        tok_next        = tok_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        tick_next       = tick_reg;
        busy_next       = busy_reg;
        ram_we          = 1'b0;
        ram_waddr       = {a_idx, tail_reg[a_idx]};
        ram_wdata       = {s_data.pkt_tag, s_data.pkt_len};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == REQ_ARRIVAL) begin
                        drop_next = 1'b1;
                        if (int'(s_data.dest_port) < NUM_PORTS
                                && cnt_reg[a_idx] < CNT_W'(QUEUE_DEPTH)) begin
                            ram_we            = 1'b1;
                            drop_next         = 1'b0;
                            tail_next[a_idx]  = (tail_reg[a_idx] == PTR_W'(QUEUE_DEPTH - 1))
                                ? '0 : tail_reg[a_idx] + PTR_W'(1);
                            cnt_next[a_idx]   = cnt_reg[a_idx] + CNT_W'(1);
                        end
                        state_next = S_ARR;
                    end else begin
                        state_next = S_REFILL;
                    end
                end
            end
            S_ARR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{sent_valid: 1'b0, sent_port: '0, sent_len: '0,
                                     sent_tag: '0, dropped: drop_reg,
                                     busy_res: busy_reg, last: 1'b1};
                    state_next   = S_IDLE;
                end
            end
            S_REFILL: begin
                if (tc0 == '0) begin
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        tok_next[i] = (sum[i] > {1'b0, cfg.cap}) ? cfg.cap
                                                               : sum[i][TOK_W-1:0];
                    end
                end
                tick_next  = (tc1 >= {1'b0, period}) ? '0 : tc1[PERIOD_W-1:0];
                state_next = S_BUSY;
            end
            S_BUSY: begin
                for (int i = 0; i < NUM_PORTS; i++) begin
                    if (CMP_W'(cnt_reg[i]) >= CMP_W'(cfg.thr)) begin
                        busy_next = 1'b1;
                    end
                end
                p_next          = '0;
                nsent_next      = '0;
                pend_valid_next = 1'b0;
                state_next      = S_READ;
            end
            S_READ: begin
                if (p_reg == VIS_W'(NUM_PORTS) || nsent_reg == SEND_CNT_W'(MAX_SENDS)) begin
                    state_next = S_FLUSH;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (cnt_reg[p_idx] != '0 && {4'd0, h_len} <= tok_reg[p_idx]) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        head_next[p_idx] = (head_reg[p_idx] == PTR_W'(QUEUE_DEPTH - 1))
                            ? '0 : head_reg[p_idx] + PTR_W'(1);
                        cnt_next[p_idx]  = cnt_dec;
                        tok_next[p_idx]  = tok_reg[p_idx] - {4'd0, h_len};
                        busy_next        = busy_after;
                        pend_valid_next  = 1'b1;
                        pend_next        = '{sent_valid: 1'b1, sent_port: 2'(p_reg),
                                             sent_len: h_len,
                                             sent_tag: ram_rdata[ENT_W-1:LEN_W],
                                             dropped: 1'b0, busy_res: busy_after,
                                             last: 1'b0};
                        nsent_next       = nsent_reg + SEND_CNT_W'(1);
                        p_next           = p_reg + VIS_W'(1);
                        state_next       = S_READ;
                    end
                end else begin
                    p_next     = p_reg + VIS_W'(1);
                    state_next = S_READ;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next      = pend_reg;
                        m_data_next.last = 1'b1;
                    end else begin
                        m_data_next = '{sent_valid: 1'b0, sent_port: '0, sent_len: '0,
                                        sent_tag: '0, dropped: 1'b0,
                                        busy_res: busy_reg, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            p_reg          <= '0;
            nsent_reg      <= '0;
            tick_reg       <= '0;
            busy_reg       <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                tok_reg[i]  <= TOK_W'(INIT_TOKENS);
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            p_reg          <= p_next;
            nsent_reg      <= nsent_next;
            tick_reg       <= tick_next;
            busy_reg       <= busy_next;
            tok_reg        <= tok_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
        end
        drop_reg   <= drop_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_drop_no_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dropped |-> !m_data.sent_valid && m_data.last)
        else $error("dropped result carries a send");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken before the first finished");

endmodule

`default_nettype wire
